[rtl/mewf_pkg.sv]
`timescale 1ns / 1ps

package mewf_pkg;

  localparam int MAX_WINDOW_STRIDES_DEF = 64;
  localparam int OFFSET_WIDTH_DEF       = 24;

  localparam int SAMPLE_W  = 16;
  localparam int SQ_W      = 31;
  localparam int CHUNK_W   = 48;
  localparam int ENERGY_W  = 48;
  localparam int WSUM_W    = 64;
  localparam int OUT_OFF_W = 24;
  localparam int STRIDE_W  = 11;
  localparam int WIN_W     = 7;
  localparam int CNT_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(320);
  localparam logic [WIN_W-1:0]    WIN_RESET    = WIN_W'(50);
  localparam logic [STRIDE_W-1:0] MAX_STRIDE   = STRIDE_W'(1024);
  localparam logic [ENERGY_W-1:0] ENERGY_MAX   = {ENERGY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIDE = 1'b0,
    REG_WINDOW = 1'b1
  } cfg_reg_t;

  typedef logic [ENERGY_W-1:0] energy_t;
  typedef logic [WSUM_W-1:0]   wsum_t;

endpackage

[rtl/max_energy_window_finder_core.sv]
`timescale 1ns / 1ps

// max_energy_window_finder_core
// finds the earliest window of window_strides chunks with the highest energy
// in a recording of signed 16-bit samples; windows start on stride boundaries
// input channel: in_valid / in_stall with in_sample, in_first, in_last;
//   in_first opens a new recording, in_last closes it and asks for a result
// result channel: out_valid / out_stall with out_peak_offset and
//   out_peak_energy, one result beat per in_last sample
// config port: cfg_we, cfg_index, cfg_wdata; index 0 stride_samples,
//   index 1 window_strides; write only while the block is idle
// throughput: one sample per clock while in_stall is low; the square, the chunk add and
//   the single ring write per closing chunk and the leaving-chunk read each take one stage
// result: the last sample's beat passes the square, chunk/ring, window sum and
//   best window stages and is then offered from the result register
// reset: synchronous, clears all running state and loads stride 320 and
//   window 50; the chunk ring needs no clearing, an entry's value is used only after
//   it has been written in the current recording
// stall: a waiting result does not block input; in_stall rises only when a
//   second result reaches the end while the first is still held by out_stall
module max_energy_window_finder_core #(
  parameter int MAX_WINDOW_STRIDES = mewf_pkg::MAX_WINDOW_STRIDES_DEF,
  parameter int OFFSET_WIDTH       = mewf_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mewf_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_first,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mewf_pkg::OUT_OFF_W-1:0]        out_peak_offset,
  output logic [mewf_pkg::ENERGY_W-1:0]         out_peak_energy,
  input  logic                                  cfg_we,
  input  logic [mewf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mewf_pkg::CFG_W-1:0]            cfg_wdata
);
  import mewf_pkg::*;

  localparam int PW = (MAX_WINDOW_STRIDES > 1) ? $clog2(MAX_WINDOW_STRIDES) : 1;
  localparam int SW = $clog2(MAX_WINDOW_STRIDES + 1);
  localparam int CW = $clog2(2 * MAX_WINDOW_STRIDES) + 1;

  // configuration
  logic [STRIDE_W-1:0] stride_r;
  logic [WIN_W-1:0]    win_r;
  logic [STRIDE_W-1:0] stride_eff;
  logic [SW-1:0]       w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
      win_r    <= WIN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_WINDOW: win_r    <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (stride_r == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (stride_r > MAX_STRIDE) begin
      stride_eff = MAX_STRIDE;
    end else begin
      stride_eff = stride_r;
    end
    if (win_r == '0) begin
      w_eff = SW'(1);
    end else if (32'(win_r) > MAX_WINDOW_STRIDES) begin
      w_eff = SW'(MAX_WINDOW_STRIDES);
    end else begin
      w_eff = SW'(win_r);
    end
  end

  // flow control
  logic hold;
  logic adv;
  logic out_valid_r;
  logic out_valid_nxt;

  logic tp_vld_r;
  logic tp_last_r;

  assign hold     = tp_vld_r && tp_last_r && out_valid_r && out_stall;
  assign adv      = !hold;
  assign in_stall = hold;

  // square stage
  logic                sq_vld_r;
  logic                sq_first_r;
  logic                sq_last_r;
  logic [SQ_W-1:0]     sq_val_r;
  logic signed [2*SAMPLE_W-1:0] prod;

  assign prod = in_sample * in_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (adv) begin
      sq_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_first_r <= in_first;
      sq_last_r  <= in_last;
      sq_val_r   <= prod[SQ_W-1:0];
    end
  end

  // chunk stage with ring write and leaving-chunk read
  logic [CHUNK_W-1:0]  chunk_energy_r, chunk_energy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic [SW-1:0]       seen_r, seen_nxt;

  logic [CHUNK_W-1:0]  ce_base, ce_sum;
  logic [CNT_W-1:0]    cnt_base;
  logic [STRIDE_W-1:0] cnt_sum;
  logic [PW-1:0]       ptr_base, ptr_inc, leave_idx;
  logic [SW-1:0]       seen_base, seen_inc;
  logic [CW-1:0]       leave_sum;
  logic                ch_close;
  logic                ch_hadwin;

  logic [CHUNK_W-1:0]  ring_mem [MAX_WINDOW_STRIDES];
  logic [CHUNK_W-1:0]  rd_r;

  always_comb begin
    ce_base   = sq_first_r ? '0 : chunk_energy_r;
    cnt_base  = sq_first_r ? '0 : cnt_r;
    ptr_base  = sq_first_r ? '0 : ptr_r;
    seen_base = sq_first_r ? '0 : seen_r;
    ce_sum    = ce_base + CHUNK_W'(sq_val_r);
    cnt_sum   = STRIDE_W'(cnt_base) + STRIDE_W'(1);
    ch_close  = sq_vld_r && (cnt_sum >= stride_eff);
    ch_hadwin = seen_base >= w_eff;
    ptr_inc   = (ptr_base == PW'(MAX_WINDOW_STRIDES - 1)) ? '0 : ptr_base + PW'(1);
    seen_inc  = (seen_base < SW'(MAX_WINDOW_STRIDES)) ? seen_base + SW'(1) : seen_base;
    leave_sum = CW'(ptr_base) + CW'(MAX_WINDOW_STRIDES) - CW'(w_eff);
    if (leave_sum >= CW'(MAX_WINDOW_STRIDES)) begin
      leave_idx = PW'(leave_sum - CW'(MAX_WINDOW_STRIDES));
    end else begin
      leave_idx = PW'(leave_sum);
    end
  end

  always_comb begin
    chunk_energy_nxt = chunk_energy_r;
    cnt_nxt          = cnt_r;
    ptr_nxt          = ptr_r;
    seen_nxt         = seen_r;
    if (sq_vld_r) begin
      if (ch_close) begin
        chunk_energy_nxt = '0;
        cnt_nxt          = '0;
        ptr_nxt          = ptr_inc;
        seen_nxt         = seen_inc;
      end else begin
        chunk_energy_nxt = ce_sum;
        cnt_nxt          = cnt_sum[CNT_W-1:0];
        ptr_nxt          = ptr_base;
        seen_nxt         = seen_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_energy_r <= '0;
      cnt_r          <= '0;
      ptr_r          <= '0;
      seen_r         <= '0;
    end else if (adv) begin
      chunk_energy_r <= chunk_energy_nxt;
      cnt_r          <= cnt_nxt;
      ptr_r          <= ptr_nxt;
      seen_r         <= seen_nxt;
    end
  end

  // read-first ring: the leaving entry may be the one overwritten this cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= ring_mem[leave_idx];
      if (ch_close) begin
        ring_mem[ptr_base] <= ce_sum;
      end
    end
  end

  // window sum stage
  logic                    wn_vld_r;
  logic                    wn_first_r;
  logic                    wn_last_r;
  logic                    wn_close_r;
  logic                    wn_hadwin_r;
  logic                    wn_full_r;
  logic [CHUNK_W-1:0]      wn_chunk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wn_vld_r <= 1'b0;
    end else if (adv) begin
      wn_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wn_first_r  <= sq_first_r;
      wn_last_r   <= sq_last_r;
      wn_close_r  <= ch_close;
      wn_hadwin_r <= ch_hadwin;
      wn_full_r   <= seen_inc >= w_eff;
      wn_chunk_r  <= ce_sum;
    end
  end

  wsum_t                   wsum_r, wsum_nxt;
  logic [OFFSET_WIDTH-1:0] start_r, start_nxt;
  wsum_t                   we_base, we_sub, we_new;
  logic [OFFSET_WIDTH-1:0] start_base, start_new;

  always_comb begin
    we_base    = wn_first_r ? '0 : wsum_r;
    start_base = wn_first_r ? '0 : start_r;
    if (!wn_hadwin_r) begin
      we_sub = we_base;
    end else if (WSUM_W'(rd_r) > we_base) begin
      we_sub = '0;
    end else begin
      we_sub = we_base - WSUM_W'(rd_r);
    end
    we_new    = we_sub + WSUM_W'(wn_chunk_r);
    start_new = wn_hadwin_r ? start_base + OFFSET_WIDTH'(stride_eff) : '0;

    wsum_nxt  = wsum_r;
    start_nxt = start_r;
    if (wn_vld_r) begin
      wsum_nxt  = we_base;
      start_nxt = start_base;
      if (wn_close_r) begin
        wsum_nxt = we_new;
        if (wn_full_r) begin
          start_nxt = start_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r  <= '0;
      start_r <= '0;
    end else if (adv) begin
      wsum_r  <= wsum_nxt;
      start_r <= start_nxt;
    end
  end

  // best window stage
  logic                    tp_first_r;
  logic                    tp_cand_r;
  wsum_t                   tp_wsum_r;
  logic [OFFSET_WIDTH-1:0] tp_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_vld_r <= 1'b0;
    end else if (adv) begin
      tp_vld_r <= wn_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp_first_r <= wn_first_r;
      tp_last_r  <= wn_last_r;
      tp_cand_r  <= wn_close_r && wn_full_r;
      tp_wsum_r  <= we_new;
      tp_off_r   <= start_new;
    end
  end

  energy_t                 top_e_r, top_e_nxt, te_base, e_sat;
  logic [OFFSET_WIDTH-1:0] top_o_r, top_o_nxt, to_base;

  always_comb begin
    te_base = tp_first_r ? '0 : top_e_r;
    to_base = tp_first_r ? '0 : top_o_r;
    e_sat   = (|tp_wsum_r[WSUM_W-1:ENERGY_W]) ? ENERGY_MAX : tp_wsum_r[ENERGY_W-1:0];

    top_e_nxt = top_e_r;
    top_o_nxt = top_o_r;
    if (tp_vld_r) begin
      top_e_nxt = te_base;
      top_o_nxt = to_base;
      if (tp_cand_r && (e_sat > te_base)) begin
        top_e_nxt = e_sat;
        top_o_nxt = tp_off_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_e_r <= '0;
      top_o_r <= '0;
    end else if (adv) begin
      top_e_r <= top_e_nxt;
      top_o_r <= top_o_nxt;
    end
  end

  // result register
  logic [OUT_OFF_W-1:0] out_off_r;
  energy_t              out_energy_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tp_vld_r && tp_last_r && adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tp_vld_r && tp_last_r && adv) begin
      out_off_r    <= OUT_OFF_W'(top_o_nxt);
      out_energy_r <= top_e_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_peak_offset = out_off_r;
  assign out_peak_energy = out_energy_r;

  // checks
  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && tp_vld_r && tp_last_r))
    else $error("input stalled without a pending result");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tp_vld_r && tp_last_r))
    else $error("result beat without a last sample");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (tp_vld_r && adv && !tp_first_r) |=> (top_e_r >= $past(top_e_r)))
    else $error("best energy dropped within a recording");

endmodule
